>>> sv/ite_pkg.sv
// Package: shared widths, constants and register indexes for the tilt estimator.
package ite_pkg;

  localparam int CordicSteps = 16;
  localparam int MaxGapUs    = 10000;
  localparam int DefaultGap  = 1000;
  localparam int ExpK        = 13493;
  localparam int AngleLimit  = 25736;
  localparam int InvGain     = 39797;
  localparam int RateScale   = 35709;

  // Datapath width for CORDIC x/y (smooth values are 40 bits, plus 4 bits of headroom).
  localparam int CW = 44;
  localparam int ZW = 20;

  localparam logic signed [ZW-1:0] HalfPi = 20'sd102944;

  typedef enum logic [2:0] {
    REG_AX  = 3'd0,
    REG_AY  = 3'd1,
    REG_AZ  = 3'd2,
    REG_GX  = 3'd3,
    REG_GY  = 3'd4,
    REG_GZ  = 3'd5,
    REG_FC  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic [31:0]        timestamp_us;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] omega_x;
    logic signed [15:0] omega_y;
    logic signed [15:0] omega_z;
  } out_item_t;

  function automatic logic signed [ZW-1:0] atan_q16(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 20'sd51472;
      5'd1:  r = 20'sd30386;
      5'd2:  r = 20'sd16055;
      5'd3:  r = 20'sd8150;
      5'd4:  r = 20'sd4091;
      5'd5:  r = 20'sd2047;
      5'd6:  r = 20'sd1024;
      5'd7:  r = 20'sd512;
      5'd8:  r = 20'sd256;
      5'd9:  r = 20'sd128;
      5'd10: r = 20'sd64;
      5'd11: r = 20'sd32;
      5'd12: r = 20'sd16;
      5'd13: r = 20'sd8;
      5'd14: r = 20'sd4;
      5'd15: r = 20'sd2;
      5'd16: r = 20'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> sv/ite_if.sv
// Interface: valid/ready channel carrying one payload.
interface ite_if #(type T = logic) (input logic clk);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> sv/imu_tilt_estimator.sv
// Top level: bias removal, decay factor, low-pass, two CORDIC passes and rate scaling.
//
//  channel | dir | fields
//  in_     | in  | accel_x/y/z, rate_x/y/z, timestamp_us
//  out_    | out | roll_angle, pitch_angle, omega_x/y/z
//  cfg_    | in  | index 0..6, data 17 bits
//
// The shared 32-step bit-serial multiplier runs every product of the 12-term decay
// series (each followed by a 36-step divide), its four squarings, the filter and the
// magnitude scaling, and the 16-step CORDIC runs twice; a zero decay skips the series.
// Sample in, result out, one at a time.
// Reset is synchronous; it restores the registers and filter state.
// A result waits in the output register; the next sample is taken meanwhile and
// holds in its last step until that register frees.
module imu_tilt_estimator (
  input  logic         clk,
  input  logic         rst_n,
  ite_if.sink          in_ch,
  ite_if.source        out_ch,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [16:0]  cfg_data
);
  import ite_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_GAP, S_X1, S_X2, S_TERM, S_TDIV, S_SQ, S_ALPHA,
    S_FY1, S_FY2, S_FZ1, S_FZ2, S_FIN, S_C1, S_MAG, S_MAGW, S_C2, S_C2W, S_OUT
  } state_t;

  state_t state_r;
  logic signed [15:0] ofs_r [6];
  logic [6:0]  fc_r;
  logic signed [39:0] sy_r, sz_r;
  logic [31:0] prev_r;
  in_item_t    it_r;
  out_item_t   res_r;
  logic        ovalid_r;
  logic signed [16:0] ofs_z_r;

  logic [35:0] t_r;          // exp argument, Q.31 (<2^31)
  logic signed [37:0] sum_r;
  logic [31:0] s_r;
  logic [3:0]  k_r;
  logic [35:0] quo_r, rem_r;
  logic [5:0]  dv_r;
  logic [16:0] alpha_r;
  logic signed [17:0] ay_r, az_r;
  logic signed [57:0] acc_r;
  logic [1:0]  ph_r;
  logic        zero_alpha_r;
  logic [31:0] gap_r;

  // shared multiplier (unsigned magnitudes; signs handled around it)
  logic        mstart_r;
  logic        mdone;
  logic [35:0] ma_r;
  logic [31:0] mb_r;
  logic [67:0] mp;
  logic        mneg_r;

  ite_mul u_mul (.clk, .rst_n, .start(mstart_r), .a_in(ma_r), .b_in(mb_r),
                 .done(mdone), .prod(mp));

  logic cstart_r;
  logic signed [CW-1:0] cy, cx, cmag;
  logic signed [ZW-1:0] cang;
  logic cdone;
  ite_cordic u_cordic (.clk, .rst_n, .start(cstart_r), .y_in(cy), .x_in(cx),
                       .done(cdone), .ang(cang), .mag(cmag));

  logic signed [ZW-1:0] roll_z_r;
  logic signed [ZW-1:0] pitch_z_r;
  logic signed [CW-1:0] magx_r;
  logic signed [CW-1:0] cy_r, cx_r;
  logic signed [17:0]   ax_r;

  assign cy = cy_r;
  assign cx = cx_r;

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = res_r;

  function automatic logic signed [15:0] sat_angle(input logic signed [ZW-1:0] z);
    logic signed [ZW-1:0] v;
    v = (z + ZW'(4)) >>> 3;
    if (v > ZW'(AngleLimit)) return 16'(AngleLimit);
    if (v < -ZW'(AngleLimit)) return -16'(AngleLimit);
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] sat_rate(input logic signed [47:0] p);
    logic signed [47:0] v;
    v = (p + 48'sd32768) >>> 16;
    if (v > 48'sd32767) return 16'sh7fff;
    if (v < -48'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  // rates: one narrow multiply each, done in the output step
  logic signed [16:0] dgx, dgy, dgz;
  assign dgx = 17'(it_r.rate_x) - 17'(ofs_r[3]);
  assign dgy = 17'(it_r.rate_y) - 17'(ofs_r[4]);
  assign dgz = 17'(it_r.rate_z) - 17'(ofs_r[5]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
      for (int i = 0; i < 6; i++) ofs_r[i] <= '0;
      ofs_z_r  <= '0;
      fc_r     <= 7'd4;
      sy_r     <= '0;
      sz_r     <= 40'sd8192 <<< 16;
      prev_r   <= '0;
      mstart_r <= 1'b0;
      cstart_r <= 1'b0;
    end else begin
      mstart_r <= 1'b0;
      cstart_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_AZ:  ofs_z_r <= cfg_data;
          REG_FC:  fc_r <= cfg_data[6:0];
          3'd7:    ;
          default: ofs_r[cfg_index] <= cfg_data[15:0];
        endcase
      end
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          it_r    <= in_ch.data;
          gap_r   <= in_ch.data.timestamp_us - prev_r;
          prev_r  <= in_ch.data.timestamp_us;
          state_r <= S_GAP;
        end
        S_GAP: begin
          if (gap_r == '0 || gap_r > 32'(MaxGapUs)) gap_r <= 32'(DefaultGap);
          ax_r <= 18'(it_r.accel_x) - 18'(ofs_r[0]);
          ay_r <= 18'(it_r.accel_y) - 18'(ofs_r[1]);
          az_r <= 18'(it_r.accel_z) - 18'(ofs_z_r);
          state_r <= S_X1;
        end
        S_X1: begin
          // fc*ExpK fits 21 bits; times gap on the serial unit
          ma_r <= 36'(fc_r) * 36'(ExpK);
          mb_r <= gap_r;
          mstart_r <= 1'b1;
          mneg_r <= 1'b0;
          state_r <= S_X2;
        end
        S_X2: if (mdone) begin
          sum_r  <= 38'sh080000000;
          k_r    <= 4'd1;
          if (mp >= (68'd16 << 31)) begin
            zero_alpha_r <= 1'b1;
            state_r <= S_ALPHA;
          end else begin
            zero_alpha_r <= 1'b0;
            t_r  <= 36'(mp >> 4);
            ma_r <= 36'h080000000;
            mb_r <= 32'(mp >> 4);
            mstart_r <= 1'b1;
            state_r <= S_TERM;
          end
        end
        S_TERM: if (mdone) begin
          // restoring divide by k, one quotient bit a cycle
          rem_r <= '0;
          quo_r <= 36'(mp >> 31);
          dv_r  <= '0;
          state_r <= S_TDIV;
        end
        S_TDIV: begin
          logic [36:0] r2;
          r2 = {rem_r, quo_r[35]};
          if (r2 >= 37'(k_r)) begin
            rem_r <= 36'(r2 - 37'(k_r));
            quo_r <= {quo_r[34:0], 1'b1};
          end else begin
            rem_r <= r2[35:0];
            quo_r <= {quo_r[34:0], 1'b0};
          end
          dv_r <= dv_r + 6'd1;
          if (dv_r == 6'd35) begin
            if (k_r[0]) sum_r <= sum_r - $signed({2'b0, quo_r[34:0], (r2 >= 37'(k_r))});
            else        sum_r <= sum_r + $signed({2'b0, quo_r[34:0], (r2 >= 37'(k_r))});
            if (k_r == 4'd12) begin
              state_r <= S_SQ;
              ph_r <= 2'd0;
              k_r  <= 4'd0;
            end else begin
              k_r  <= k_r + 4'd1;
              ma_r <= {quo_r[34:0], (r2 >= 37'(k_r))};
              mb_r <= t_r[31:0];
              mstart_r <= 1'b1;
              state_r <= S_TERM;
            end
          end
        end
        S_SQ: begin
          if (ph_r == 2'd0) begin
            if (k_r == 4'd0) begin
              if (sum_r < 0) s_r <= '0;
              else if (sum_r > 38'sh080000000) s_r <= 32'h80000000;
              else s_r <= sum_r[31:0];
              ph_r <= 2'd1;
            end else begin
              ph_r <= 2'd1;
            end
          end else if (ph_r == 2'd1) begin
            if (k_r == 4'd4) state_r <= S_ALPHA;
            else begin
              ma_r <= {4'd0, s_r};
              mb_r <= s_r;
              mstart_r <= 1'b1;
              ph_r <= 2'd2;
            end
          end else if (mdone) begin
            s_r  <= 32'((mp + (68'd1 << 30)) >> 31);
            k_r  <= k_r + 4'd1;
            ph_r <= 2'd1;
          end
        end
        S_ALPHA: begin
          if (zero_alpha_r) alpha_r <= '0;
          else if (((33'(s_r) + 33'd16384) >> 15) > 33'd65535) alpha_r <= 17'd65535;
          else alpha_r <= 17'((33'(s_r) + 33'd16384) >> 15);
          state_r <= S_FY1;
        end
        S_FY1: begin
          // alpha*|sy|; the sample term is narrow and done directly
          ma_r <= 36'(sy_r < 0 ? -sy_r : sy_r);
          mneg_r <= sy_r < 0;
          mb_r <= 32'(alpha_r);
          mstart_r <= 1'b1;
          state_r <= S_FY2;
        end
        S_FY2: if (mdone) begin
          acc_r <= 58'(mneg_r ? -$signed({1'b0, mp[56:0]}) : $signed({1'b0, mp[56:0]}))
                 + ((58'(ay_r) * 58'(17'd65536 - alpha_r)) <<< 16) + 58'sd32768;
          ph_r  <= 2'd1;
          state_r <= S_FIN;
        end
        S_FZ1: begin
          ma_r <= 36'(sz_r < 0 ? -sz_r : sz_r);
          mneg_r <= sz_r < 0;
          mb_r <= 32'(alpha_r);
          mstart_r <= 1'b1;
          state_r <= S_FZ2;
        end
        S_FZ2: if (mdone) begin
          acc_r <= 58'(mneg_r ? -$signed({1'b0, mp[56:0]}) : $signed({1'b0, mp[56:0]}))
                 + ((58'(az_r) * 58'(17'd65536 - alpha_r)) <<< 16) + 58'sd32768;
          ph_r  <= 2'd2;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (ph_r == 2'd1) begin
            sy_r <= 40'(acc_r >>> 16);
            state_r <= S_FZ1;
          end else begin
            sz_r <= 40'(acc_r >>> 16);
            cy_r <= CW'(sy_r);
            cx_r <= CW'(40'(acc_r >>> 16));
            cstart_r <= 1'b1;
            state_r <= S_C1;
          end
        end
        S_C1: if (cdone) begin
          roll_z_r <= cang;
          magx_r   <= cmag;
          state_r  <= S_MAG;
        end
        S_MAG: begin
          ma_r <= 36'(magx_r);
          mb_r <= 32'(InvGain);
          mneg_r <= 1'b0;
          mstart_r <= 1'b1;
          state_r <= S_MAGW;
        end
        S_MAGW: if (mdone) begin
          cx_r <= CW'((mp + 68'd32768) >> 16);
          cy_r <= -(CW'(ax_r) <<< 16);
          cstart_r <= 1'b1;
          state_r <= S_C2;
        end
        S_C2: if (cdone) begin
          pitch_z_r <= cang;
          state_r   <= S_OUT;
        end
        S_OUT: if (!ovalid_r || out_ch.ready) begin
          // hold until the previous result leaves
          res_r.roll_angle  <= sat_angle(roll_z_r);
          res_r.pitch_angle <= sat_angle(pitch_z_r);
          res_r.omega_x <= sat_rate(48'(dgx) * 48'sd35709);
          res_r.omega_y <= sat_rate(48'(dgy) * 48'sd35709);
          res_r.omega_z <= sat_rate(48'(dgz) * 48'sd35709);
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovalid_r) |-> $past(state_r) == S_OUT) else $error("stray result");
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FY1) |-> alpha_r <= 17'd65535) else $error("alpha out of range");

endmodule

>>> sv/ite_cordic.sv
// Vectoring CORDIC: one micro-rotation per cycle, returns angle and raw magnitude.
module ite_cordic (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [ite_pkg::CW-1:0] y_in,
  input  logic signed [ite_pkg::CW-1:0] x_in,
  output logic                         done,
  output logic signed [ite_pkg::ZW-1:0] ang,
  output logic signed [ite_pkg::CW-1:0] mag
);
  import ite_pkg::*;

  logic signed [CW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;
  logic [4:0]           i_r;
  logic                 busy_r, done_r;

  assign done = done_r;
  assign ang  = z_r;
  assign mag  = x_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        i_r <= '0;
        if (x_in == '0 && y_in == '0) begin
          x_r <= '0; y_r <= '0; z_r <= '0;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          if (x_in < 0) begin
            if (y_in >= 0) begin
              x_r <= y_in; y_r <= -x_in; z_r <= HalfPi;
            end else begin
              x_r <= -y_in; y_r <= x_in; z_r <= -HalfPi;
            end
          end else begin
            x_r <= x_in; y_r <= y_in; z_r <= '0;
          end
        end
      end else if (busy_r) begin
        if (y_r >= 0) begin
          x_r <= x_r + (y_r >>> i_r);
          y_r <= y_r - (x_r >>> i_r);
          z_r <= z_r + atan_q16(i_r);
        end else begin
          x_r <= x_r - (y_r >>> i_r);
          y_r <= y_r + (x_r >>> i_r);
          z_r <= z_r - atan_q16(i_r);
        end
        i_r <= i_r + 5'd1;
        if (i_r == 5'(CordicSteps - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("cordic done while busy");
  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> i_r < 5'(CordicSteps)) else $error("cordic step overrun");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r || $past(start)) else $error("cordic done held");

endmodule

>>> sv/ite_mul.sv
// Bit-serial multiplier: unsigned 36-bit multiplicand times 32-bit multiplier, one bit a cycle.
module ite_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [35:0] a_in,
  input  logic [31:0] b_in,
  output logic        done,
  output logic [67:0] prod
);
  logic [67:0] acc_r;
  logic [35:0] a_r;
  logic [31:0] b_r;
  logic [5:0]  n_r;
  logic        busy_r, done_r;

  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a_in;
        b_r    <= b_in;
        acc_r  <= '0;
        n_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        // shift-add from the top bit of the multiplier
        acc_r <= {acc_r[66:0], 1'b0} + (b_r[31] ? {32'd0, a_r} : 68'd0);
        b_r   <= {b_r[30:0], 1'b0};
        n_r   <= n_r + 6'd1;
        if (n_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  a_mul_len: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> n_r < 6'd32) else $error("multiplier overrun");
  a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("multiplier done while busy");
  a_mul_start: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> busy_r) else $error("multiplier did not start");

endmodule

>>> verif/tb.sv
// Testbench for imu_tilt_estimator: directed and random samples checked against a tilt predictor.
`timescale 1ns / 1ps

module tb;
  import ite_pkg::*;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [16:0] cfg_data;

  ite_if #(in_item_t) in_if (clk);
  ite_if #(out_item_t) out_if (clk);

  imu_tilt_estimator i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // mirror of the bias and cutoff registers and of the filter state
  longint bias_ax, bias_ay, bias_az, bias_gx, bias_gy, bias_gz, cutoff;
  longint smooth_y_q, smooth_z_q;
  logic [31:0] last_stamp;
  logic [31:0] stamp_now;
  out_item_t expected_poses[$];
  int mismatches;
  int send_idle_pct, recv_stall_pct, hold_cycles;
  longint atan_steps[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                             256, 128, 64, 32, 16, 8, 4, 2, 1};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint decay_q16(input longint fc, input longint gap);
    longint x, t, term, sum, s, a;
    x = fc * gap * ExpK;
    if (x >= (longint'(16) <<< 31)) return 0;
    t = x >>> 4;
    term = longint'(1) <<< 31;
    sum = term;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * t) >>> 31) / k;
      sum = (k % 2 == 1) ? sum - term : sum + term;
    end
    s = clip(sum, 0, longint'(1) <<< 31);
    for (int k = 0; k < 4; k++) s = (s * s + (longint'(1) <<< 30)) >>> 31;
    a = (s + (1 << 14)) >>> 15;
    return clip(a, 0, 65535);
  endfunction

  function automatic void vector_angle(input longint y0, input longint x0,
                                       output longint ang, output longint mag);
    longint x, y, z, t, dx, dy;
    x = x0;
    y = y0;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0;
      mag = 0;
      return;
    end
    // pre-rotate into the right half plane
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = HalfPi;
      end else begin
        x = -y;
        y = t;
        z = -HalfPi;
      end
    end
    for (int i = 0; i < CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += (i < 17) ? atan_steps[i] : 0;
      end else begin
        x -= dx;
        y += dy;
        z -= (i < 17) ? atan_steps[i] : 0;
      end
    end
    ang = z;
    mag = x;
  endfunction

  function automatic logic [15:0] rate_out(input longint diff);
    return 16'(clip((diff * RateScale + 32768) >>> 16, -32768, 32767));
  endfunction

  function automatic void predict_pose(input in_item_t s);
    longint ax, ay, az, alpha, roll_z, pitch_z, mag, unused;
    logic [31:0] gap;
    out_item_t r;
    ax = longint'($signed(s.accel_x)) - bias_ax;
    ay = longint'($signed(s.accel_y)) - bias_ay;
    az = longint'($signed(s.accel_z)) - bias_az;
    gap = s.timestamp_us - last_stamp;
    last_stamp = s.timestamp_us;
    if (gap == 0 || gap > MaxGapUs) gap = DefaultGap;
    alpha = decay_q16(cutoff, longint'(gap));
    smooth_y_q = (alpha * smooth_y_q + (65536 - alpha) * (ay * 65536) + 32768) >>> 16;
    smooth_z_q = (alpha * smooth_z_q + (65536 - alpha) * (az * 65536) + 32768) >>> 16;
    vector_angle(smooth_y_q, smooth_z_q, roll_z, mag);
    mag = (mag * InvGain + 32768) >>> 16;
    vector_angle(-ax * 65536, mag, pitch_z, unused);
    r.roll_angle  = 16'(clip((roll_z + 4) >>> 3, -AngleLimit, AngleLimit));
    r.pitch_angle = 16'(clip((pitch_z + 4) >>> 3, -AngleLimit, AngleLimit));
    r.omega_x = rate_out(longint'($signed(s.rate_x)) - bias_gx);
    r.omega_y = rate_out(longint'($signed(s.rate_y)) - bias_gy);
    r.omega_z = rate_out(longint'($signed(s.rate_z)) - bias_gz);
    expected_poses.push_back(r);
  endfunction

  // predict on every accepted request
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) predict_pose(in_if.data);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_if.data);
      end else begin
        want = expected_poses.pop_front();
        if (out_if.data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch roll %0d/%0d pitch %0d/%0d wx %0d/%0d wy %0d/%0d wz %0d/%0d",
                     want.roll_angle, out_if.data.roll_angle,
                     want.pitch_angle, out_if.data.pitch_angle,
                     want.omega_x, out_if.data.omega_x, want.omega_y, out_if.data.omega_y,
                     want.omega_z, out_if.data.omega_z);
        end
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  always @(negedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_sample(input in_item_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= s;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_if.valid <= 1'b0;
    while (expected_poses.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [16:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_AX: bias_ax = longint'($signed(v[15:0]));
      REG_AY: bias_ay = longint'($signed(v[15:0]));
      REG_AZ: bias_az = longint'($signed(v));
      REG_GX: bias_gx = longint'($signed(v[15:0]));
      REG_GY: bias_gy = longint'($signed(v[15:0]));
      REG_GZ: bias_gz = longint'($signed(v[15:0]));
      REG_FC: cutoff = longint'(v[6:0]);
      default: ;
    endcase
  endtask

  function automatic in_item_t make_sample(input int ax, input int ay, input int az,
                                           input int gx, input int gy, input int gz,
                                           input logic [31:0] stamp);
    in_item_t s;
    s.accel_x = 16'(ax);
    s.accel_y = 16'(ay);
    s.accel_z = 16'(az);
    s.rate_x = 16'(gx);
    s.rate_y = 16'(gy);
    s.rate_z = 16'(gz);
    s.timestamp_us = stamp;
    return s;
  endfunction

  // mostly a plausible tilted sensor at ~1 kHz; sometimes raw noise or odd gaps
  function automatic in_item_t random_sample();
    int gap_pick;
    gap_pick = $urandom_range(99);
    if (gap_pick < 80) stamp_now += $urandom_range(500, 2000);
    else if (gap_pick < 85) stamp_now += 0;
    else if (gap_pick < 90) stamp_now += $urandom_range(10001, 200000);
    else if (gap_pick < 95) stamp_now += $urandom_range(1, 10000);
    else stamp_now = $urandom;
    if ($urandom_range(99) < 75)
      return make_sample($urandom_range(0, 16384) - 8192, $urandom_range(0, 16384) - 8192,
                         $urandom_range(0, 16384) - 8192, $urandom_range(0, 4000) - 2000,
                         $urandom_range(0, 4000) - 2000, $urandom_range(0, 4000) - 2000,
                         stamp_now);
    return make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, stamp_now);
  endfunction

  task automatic random_config();
    write_reg(REG_AX, 17'($urandom));
    write_reg(REG_AY, 17'($urandom));
    write_reg(REG_AZ, 17'($urandom));
    write_reg(REG_GX, 17'($urandom));
    write_reg(REG_GY, 17'($urandom));
    write_reg(REG_GZ, 17'($urandom));
    write_reg(REG_FC, 17'($urandom_range(1, 100)) | (17'($urandom) & 17'h1ff80));
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // first sample after reset measures its gap from time 0; also zero gap
    send_sample(make_sample(0, 0, 8192, 0, 0, 0, 32'd1000));
    send_sample(make_sample(0, 0, 8192, 0, 0, 0, 32'd1000));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767, 32'd11000));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768, 32'd21001));
    send_sample(make_sample(-32768, 0, -32768, 0, 0, 0, 32'hffff_ffff));
    send_sample(make_sample(8192, -8192, -100, 1, -1, 0, 32'd9999));
    go_idle();
    // extreme biases drive the rates into saturation
    write_reg(REG_GX, 17'h08000);
    write_reg(REG_GY, 17'h07fff);
    write_reg(REG_GZ, 17'h08000);
    write_reg(REG_AZ, 17'h10000);
    write_reg(REG_FC, 17'd100);
    send_sample(make_sample(32767, 100, 32767, 32767, -32768, 32767, 32'd10000));
    send_sample(make_sample(-32768, -100, 32767, -32768, 32767, -32768, 32'd20000));
    go_idle();
    write_reg(REG_AZ, 17'h0ffff);
    write_reg(REG_FC, 17'd1);
    send_sample(make_sample(0, 32767, -32768, 0, 0, 0, 32'd20001));
    go_idle();
    // cutoff of zero clamps alpha to its top
    write_reg(REG_FC, 17'd0);
    send_sample(make_sample(100, 200, 300, 1, 2, 3, 32'd21001));
    go_idle();
    // drain the filter toward the origin for a zero vector
    write_reg(REG_AX, 17'd0);
    write_reg(REG_AY, 17'd0);
    write_reg(REG_AZ, 17'd0);
    write_reg(REG_FC, 17'd100);
    stamp_now = 32'd21001;
    for (int i = 0; i < 10; i++) begin
      stamp_now += 10000;
      send_sample(make_sample(0, 0, 0, 0, 0, 0, stamp_now));
    end
    go_idle();
  endtask

  task automatic test_random_phase(input int count, input int s_pct, input int r_pct);
    random_config();
    send_idle_pct = s_pct;
    recv_stall_pct = r_pct;
    for (int i = 0; i < count; i++) send_sample(random_sample());
    go_idle();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 3000;
    for (int i = 0; i < 20; i++) send_sample(random_sample());
    go_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_AX;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    bias_ax = 0; bias_ay = 0; bias_az = 0;
    bias_gx = 0; bias_gy = 0; bias_gz = 0;
    cutoff = 4;
    smooth_y_q = 0;
    smooth_z_q = longint'(8192) * 65536;
    last_stamp = '0;
    stamp_now = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_random_phase(460, 0, 0);
    test_random_phase(460, 58, 0);
    test_random_phase(460, 0, 58);
    test_random_phase(460, 20, 20);
    test_backpressure();
    write_reg(REG_FC, 17'd1);
    test_random_phase(0, 0, 0);
    if (mismatches == 0 && expected_poses.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #400_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
